[src/fcpm_pkg.sv]
`default_nettype none

package fcpm_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_VOLT_GAIN  = 3'd0,
    REG_FAN_SQ     = 3'd1,
    REG_FAN_LIN    = 3'd2,
    REG_FAN_CONST  = 3'd3,
    REG_DUTY_SQ    = 3'd4,
    REG_DUTY_LIN   = 3'd5,
    REG_DUTY_CONST = 3'd6
  } cfg_reg_e;

  // fixed-point constants
  localparam int          GAIN_W        = 16;
  localparam int          VOLT_W        = 20;
  localparam int          PCT_W         = 15;
  localparam int          LVL_W         = 8;
  localparam int          CLAMP_W       = 23;
  localparam logic [15:0] VOLT_GAIN_RST = 16'd14207;
  localparam logic [19:0] VOLT_MAX      = 20'hFFFFF;
  localparam logic [22:0] HUNDRED_Q16   = 23'd6553600;
  // floor(q / 100) as (q * 5243) >> 19, exact for q below 25600
  localparam logic [12:0] PWM_RECIP     = 13'd5243;
  localparam int          PWM_SHIFT     = 19;

  // one quadratic's coefficients, signed Q16.16
  typedef struct packed {
    logic signed [31:0] sq;
    logic signed [31:0] lin;
    logic signed [31:0] cst;
  } coef_t;

  // floor of a 64-bit product over 2^16, saturated to signed 32 bits
  function automatic logic signed [31:0] sat_shr16(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> 16;
    if (!sh[63] && (|sh[62:31])) begin
      sat_shr16 = 32'sh7FFF_FFFF;
    end else if (sh[63] && !(&sh[62:31])) begin
      sat_shr16 = 32'sh8000_0000;
    end else begin
      sat_shr16 = sh[31:0];
    end
  endfunction

  // signed 32-bit add with saturation
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[src/fcpm_volt.sv]
`default_nettype none

module fcpm_volt import fcpm_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic [ADC_BITS-1:0] adc_i,
  input  wire logic [GAIN_W-1:0]   gain_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic signed [31:0]       volt_o
);

  localparam int NS = 2;
  localparam int PW = ADC_BITS + GAIN_W;
  localparam int SW = PW - 4;
  localparam logic [SW-1:0] VMAX = SW'(VOLT_MAX);

  logic [NS:0]    en;
  logic [NS-1:0]  v_q, v_d, v_in;
  logic [PW-1:0]  prod_q, prod_d;
  logic [SW-1:0]  shifted;
  logic [VOLT_W-1:0] volt_q, volt_d;

  // stage enables, a stage loads when empty or when the next one moves
  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NS-2:0], valid_i};
  assign v_d  = (en[NS-1:0] & v_in) | (~en[NS-1:0] & v_q);

  // count times gain, then drop four bits and saturate to Q4.16
  assign prod_d  = PW'(adc_i) * PW'(gain_i);
  assign shifted = prod_q[PW-1:4];
  assign volt_d  = (shifted > VMAX) ? VOLT_MAX : shifted[VOLT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
    end
    if (en[1]) begin
      volt_q <= volt_d;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign volt_o  = signed'(32'(volt_q));

endmodule

`default_nettype wire

[src/fcpm_curve.sv]
`default_nettype none

module fcpm_curve import fcpm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire coef_t              coef_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic signed [31:0] x_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic signed [31:0]      y_o,
  output logic signed [31:0]      x_o
);

  localparam int NS = 6;

  logic [NS:0]   en;
  logic [NS-1:0] v_q, v_d, v_in;

  logic signed [63:0] m1_q, m3_q, m2_q;
  logic signed [31:0] t1_q, t2_q, s_q, y_q;
  logic signed [31:0] t3a_q, t3b_q, t3c_q;
  logic signed [31:0] x_q [NS];

  // stage enables, a stage loads when empty or when the next one moves
  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NS-2:0], valid_i};
  assign v_d  = (en[NS-1:0] & v_in) | (~en[NS-1:0] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // the argument travels with the beat
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        x_q[k] <= (k == 0) ? x_i : x_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // square and linear products, then floor and saturate each
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m1_q <= 64'(coef_i.sq) * 64'(x_i);
      m3_q <= 64'(coef_i.lin) * 64'(x_i);
    end
    if (en[1]) begin
      t1_q  <= sat_shr16(m1_q);
      t3a_q <= sat_shr16(m3_q);
    end
    // second pass of the square term
    if (en[2]) begin
      m2_q  <= 64'(t1_q) * 64'(x_q[1]);
      t3b_q <= t3a_q;
    end
    if (en[3]) begin
      t2_q  <= sat_shr16(m2_q);
      t3c_q <= t3b_q;
    end
    // sum of terms, then constant
    if (en[4]) begin
      s_q <= sat_add(t2_q, t3c_q);
    end
    if (en[5]) begin
      y_q <= sat_add(s_q, coef_i.cst);
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign y_o     = y_q;
  assign x_o     = x_q[NS-1];

endmodule

`default_nettype wire

[src/fcpm_out.sv]
`default_nettype none

module fcpm_out import fcpm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic signed [31:0] fan_i,
  input  wire logic signed [31:0] duty_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [PCT_W-1:0]        fan_pct_o,
  output logic [PCT_W-1:0]        duty_pct_o,
  output logic [LVL_W-1:0]        pwm_lvl_o
);

  localparam int NS  = 2;
  localparam int SCW = CLAMP_W + 8;
  localparam int RW  = PCT_W + 13;

  logic [NS:0]   en;
  logic [NS-1:0] v_q, v_d, v_in;

  logic [CLAMP_W-1:0] fan_c, duty_c, fan_c_q, duty_c_q;
  logic [SCW-1:0]     duty_x255;
  logic [PCT_W-1:0]   q_d, q_q;
  logic [RW-1:0]      recip;
  logic [PCT_W-1:0]   fan_pct_q, duty_pct_q;
  logic [LVL_W-1:0]   lvl_q;

  // stage enables, a stage loads when empty or when the next one moves
  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NS-2:0], valid_i};
  assign v_d  = (en[NS-1:0] & v_in) | (~en[NS-1:0] & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // clamp to 0..100 in Q16.16
  always_comb begin
    if (fan_i[31]) begin
      fan_c = '0;
    end else if (fan_i[30:0] > 31'(HUNDRED_Q16)) begin
      fan_c = HUNDRED_Q16;
    end else begin
      fan_c = fan_i[CLAMP_W-1:0];
    end
    if (duty_i[31]) begin
      duty_c = '0;
    end else if (duty_i[30:0] > 31'(HUNDRED_Q16)) begin
      duty_c = HUNDRED_Q16;
    end else begin
      duty_c = duty_i[CLAMP_W-1:0];
    end
  end

  // duty * 255 / 2^16, the divide by 100 follows
  assign duty_x255 = {duty_c, 8'd0} - SCW'(duty_c);
  assign q_d       = duty_x255[SCW-1:16];
  assign recip     = RW'(q_q) * RW'(PWM_RECIP);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fan_c_q  <= fan_c;
      duty_c_q <= duty_c;
      q_q      <= q_d;
    end
    if (en[1]) begin
      fan_pct_q  <= fan_c_q[CLAMP_W-1:8];
      duty_pct_q <= duty_c_q[CLAMP_W-1:8];
      lvl_q      <= recip[PWM_SHIFT+LVL_W-1:PWM_SHIFT];
    end
  end

  assign ready_o    = en[0];
  assign valid_o    = v_q[NS-1];
  assign fan_pct_o  = fan_pct_q;
  assign duty_pct_o = duty_pct_q;
  assign pwm_lvl_o  = lvl_q;

endmodule

`default_nettype wire

[src/fan_curve_pwm_map.sv]
`default_nettype none

// Fan curve to PWM map. Each converter sample on the slave stream is scaled
// by volt_gain to a Q4.16 voltage, run through the fan quadratic and then the
// duty quadratic (signed Q16.16, saturating), and leaves on the master stream
// as fan percent and duty percent in Q7.8 (clamped to 0..100) plus an 8-bit
// PWM level. One sample is taken per clock while the master side keeps up;
// the voltage scale, each quadratic (two multiplier passes, each floored and
// saturated, then two saturating adds) and clamp and level are registered
// stages. Every stage holds its own valid bit, so bubbles close up and a
// stalled result holds back samples in flight only once the stages ahead are
// full. Registers are written through the cfg port, which is always ready;
// write them only while no sample is in the pipe. Unknown indices are ignored.

module fan_curve_pwm_map import fcpm_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // slave stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // [ADC_BITS-1:0] adc_sample
  input  wire logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
  // master stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [14:0] fan_percent, [29:15] duty_percent, [37:30] pwm_level, [39:38] zero
  output logic [39:0]                       m_axis_tdata,
  // register writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0]        cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data_i
);

  logic [GAIN_W-1:0] volt_gain_q;
  coef_t             fan_coef_q, duty_coef_q;

  logic               volt_valid, volt_ready;
  logic signed [31:0] volt;
  logic               fan_valid, fan_ready;
  logic signed [31:0] fan;
  logic               duty_valid, duty_ready;
  logic signed [31:0] duty, fan_dly;
  logic [PCT_W-1:0]   fan_pct, duty_pct;
  logic [LVL_W-1:0]   pwm_lvl;

  // register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_gain_q <= VOLT_GAIN_RST;
      fan_coef_q  <= '0;
      duty_coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_VOLT_GAIN:  volt_gain_q     <= cfg_data_i[GAIN_W-1:0];
        REG_FAN_SQ:     fan_coef_q.sq   <= cfg_data_i;
        REG_FAN_LIN:    fan_coef_q.lin  <= cfg_data_i;
        REG_FAN_CONST:  fan_coef_q.cst  <= cfg_data_i;
        REG_DUTY_SQ:    duty_coef_q.sq  <= cfg_data_i;
        REG_DUTY_LIN:   duty_coef_q.lin <= cfg_data_i;
        REG_DUTY_CONST: duty_coef_q.cst <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // voltage scale
  fcpm_volt #(
    .ADC_BITS (ADC_BITS)
  ) u_volt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .adc_i   (s_axis_tdata[ADC_BITS-1:0]),
    .gain_i  (volt_gain_q),
    .valid_o (volt_valid),
    .ready_i (volt_ready),
    .volt_o  (volt)
  );

  // fan curve
  fcpm_curve u_fan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (fan_coef_q),
    .valid_i (volt_valid),
    .ready_o (volt_ready),
    .x_i     (volt),
    .valid_o (fan_valid),
    .ready_i (fan_ready),
    .y_o     (fan),
    .x_o     ()
  );

  // duty curve, the fan value rides along as its argument
  fcpm_curve u_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (duty_coef_q),
    .valid_i (fan_valid),
    .ready_o (fan_ready),
    .x_i     (fan),
    .valid_o (duty_valid),
    .ready_i (duty_ready),
    .y_o     (duty),
    .x_o     (fan_dly)
  );

  // clamp, Q7.8 and PWM level
  fcpm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (duty_valid),
    .ready_o    (duty_ready),
    .fan_i      (fan_dly),
    .duty_i     (duty),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .fan_pct_o  (fan_pct),
    .duty_pct_o (duty_pct),
    .pwm_lvl_o  (pwm_lvl)
  );

  assign m_axis_tdata = {2'b00, pwm_lvl, duty_pct, fan_pct};

  // checks
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_fan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fan_pct <= 15'd25600) && (duty_pct <= 15'd25600))
    else $error("percent above 100");

  a_pwm_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (duty_pct == 15'd25600) |-> (pwm_lvl == 8'd255))
    else $error("full duty without full level");

  a_pwm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (duty_pct == 15'd0) |-> (pwm_lvl == 8'd0))
    else $error("zero duty with nonzero level");

endmodule

`default_nettype wire
